[hw/rtl/ftrb_pkg.sv]
// ftrb_pkg: types and constants shared by the filtered trace ring buffer
// no dependencies; used by ftrb_cfg, ftrb_ctrl, ftrb_dp and filtered_trace_ring_buffer
package ftrb_pkg;

  localparam int HELD_W     = 9;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 64;

  localparam logic [HELD_W-1:0] RING_SIZE_RESET = 9'd256;

  localparam logic [1:0] REQ_RECORD = 2'd0;
  localparam logic [1:0] REQ_POP    = 2'd1;
  localparam logic [1:0] REQ_PEEK   = 2'd2;
  localparam logic [1:0] REQ_CLEAR  = 2'd3;

  localparam logic [CFG_IDX_W-1:0] CFG_RECORDING = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_RING_SIZE = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_FILTER_0  = 3'd2;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [7:0]  event_code;
    logic [7:0]  task_number;
    logic [15:0] small_param;
    logic [31:0] large_param;
    logic [31:0] time_stamp;
    logic [7:0]  peek_offset;
  } in_item_t;

  typedef struct packed {
    logic              entry_valid;
    logic [31:0]       out_time;
    logic [7:0]        out_event;
    logic [7:0]        out_task;
    logic [15:0]       out_small_param;
    logic [31:0]       out_large_param;
    logic [HELD_W-1:0] entries_held;
    logic [31:0]       overflow_total;
  } out_item_t;

  typedef struct packed {
    logic [31:0] stamp;
    logic [7:0]  code;
    logic [7:0]  task_num;
    logic [15:0] small_p;
    logic [31:0] large_p;
  } entry_t;

  typedef struct packed {
    logic              recording_on;
    logic [HELD_W-1:0] size_in_use;
    logic              clear;
  } cfg_ctl_t;

  typedef struct packed {
    logic capture;
    logic execute;
  } dp_cmd_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_RESP
  } state_t;

endpackage

[hw/rtl/ftrb_cfg.sv]
// ftrb_cfg: configuration registers (recording enable, ring size, event filter)
// depends on ftrb_pkg
module ftrb_cfg #(
  parameter int RING_DEPTH  = 256,
  parameter int EVENT_CODES = 256
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [ftrb_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [ftrb_pkg::CFG_DATA_W-1:0]  cfg_data,
  output ftrb_pkg::cfg_ctl_t               ctl,
  output logic [EVENT_CODES-1:0]           filter
);

  localparam int DEPTH_CAP = (RING_DEPTH > 511) ? 511 : RING_DEPTH;

  logic                        rec_r;
  logic [ftrb_pkg::HELD_W-1:0] ring_size_r;
  logic [EVENT_CODES-1:0]      filter_r;
  logic                        clear_r;
  logic                        wr;

  assign cfg_ready = 1'b1;
  assign wr        = cfg_valid & cfg_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rec_r       <= 1'b0;
      ring_size_r <= ftrb_pkg::RING_SIZE_RESET;
      clear_r     <= 1'b0;
    end else begin
      clear_r <= wr && (cfg_index == ftrb_pkg::CFG_RING_SIZE);
      if (wr && cfg_index == ftrb_pkg::CFG_RECORDING) begin
        rec_r <= cfg_data[0];
      end
      if (wr && cfg_index == ftrb_pkg::CFG_RING_SIZE) begin
        ring_size_r <= cfg_data[ftrb_pkg::HELD_W-1:0];
      end
    end
  end

  for (genvar i = 0; i < EVENT_CODES; i++) begin : g_filter
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        filter_r[i] <= 1'b1;
      end else if (wr && cfg_index == ftrb_pkg::CFG_FILTER_0 + 3'(i / 64)) begin
        filter_r[i] <= cfg_data[i % 64];
      end
    end
  end

  always_comb begin
    ctl.recording_on = rec_r;
    ctl.clear        = clear_r;
    if (ring_size_r == '0) begin
      ctl.size_in_use = 9'd1;
    end else if (ring_size_r > 9'(DEPTH_CAP)) begin
      ctl.size_in_use = 9'(DEPTH_CAP);
    end else begin
      ctl.size_in_use = ring_size_r;
    end
  end

  assign filter = filter_r;

endmodule

[hw/rtl/ftrb_ctrl.sv]
// ftrb_ctrl: request sequencer, capture then execute then respond
// depends on ftrb_pkg
module ftrb_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  output logic              out_strobe,
  output ftrb_pkg::dp_cmd_t cmd
);

  ftrb_pkg::state_t state_r;
  ftrb_pkg::state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ftrb_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ftrb_pkg::ST_IDLE: begin
        if (start) state_nxt = ftrb_pkg::ST_EXEC;
      end
      ftrb_pkg::ST_EXEC: state_nxt = ftrb_pkg::ST_RESP;
      ftrb_pkg::ST_RESP: state_nxt = ftrb_pkg::ST_IDLE;
      default:           state_nxt = ftrb_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    busy        = 1'b1;
    out_strobe  = 1'b0;
    cmd.capture = 1'b0;
    cmd.execute = 1'b0;
    unique case (state_r)
      ftrb_pkg::ST_IDLE: begin
        busy        = 1'b0;
        cmd.capture = start;
      end
      ftrb_pkg::ST_EXEC: cmd.execute = 1'b1;
      ftrb_pkg::ST_RESP: out_strobe  = 1'b1;
      default:           busy        = 1'b1;
    endcase
  end

endmodule

[hw/rtl/ftrb_dp.sv]
// ftrb_dp: entry memory, ring pointers, held and overflow counters, result register
// depends on ftrb_pkg
module ftrb_dp #(
  parameter int RING_DEPTH  = 256,
  parameter int EVENT_CODES = 256
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  ftrb_pkg::dp_cmd_t      cmd,
  input  ftrb_pkg::in_item_t     in_item,
  input  ftrb_pkg::cfg_ctl_t     ctl,
  input  logic [EVENT_CODES-1:0] filter,
  output ftrb_pkg::out_item_t    out_item
);

  localparam int PTR_W  = $clog2(RING_DEPTH);
  localparam int CMP_W  = (PTR_W + 1 > 10) ? PTR_W + 1 : 10;
  localparam int CODE_W = $clog2(EVENT_CODES);
  localparam int HW     = ftrb_pkg::HELD_W;

  ftrb_pkg::entry_t   mem [RING_DEPTH];
  ftrb_pkg::entry_t   rdata_r;
  ftrb_pkg::entry_t   wdata;
  ftrb_pkg::in_item_t req_r;

  logic [PTR_W-1:0] write_slot_r, write_slot_nxt;
  logic [PTR_W-1:0] oldest_r, oldest_nxt;
  logic [HW-1:0]    held_r, held_nxt;
  logic [31:0]      ovf_r, ovf_nxt;
  logic             got_r, got_nxt;
  logic             wr_en, rd_en;
  logic [PTR_W-1:0] rd_addr;
  logic             code_ok;
  logic [CMP_W-1:0] psum, pdiff;

  function automatic logic [PTR_W-1:0] next_slot(input logic [PTR_W-1:0] slot,
                                                 input logic [HW-1:0]    size);
    logic [CMP_W-1:0] n;
    n = CMP_W'(slot) + CMP_W'(1);
    return (n >= CMP_W'(size)) ? '0 : n[PTR_W-1:0];
  endfunction

  always_ff @(posedge clk) begin
    if (cmd.capture) req_r <= in_item;
  end

  assign code_ok = ({1'b0, req_r.event_code} < 9'(EVENT_CODES))
                   && filter[req_r.event_code[CODE_W-1:0]];

  assign psum  = CMP_W'(oldest_r) + CMP_W'(req_r.peek_offset);
  assign pdiff = psum - CMP_W'(ctl.size_in_use);

  assign wdata.stamp    = req_r.time_stamp;
  assign wdata.code     = req_r.event_code;
  assign wdata.task_num = req_r.task_number;
  assign wdata.small_p  = req_r.small_param;
  assign wdata.large_p  = req_r.large_param;

  always_comb begin
    write_slot_nxt = write_slot_r;
    oldest_nxt     = oldest_r;
    held_nxt       = held_r;
    ovf_nxt        = ovf_r;
    got_nxt        = got_r;
    wr_en          = 1'b0;
    rd_en          = 1'b0;
    rd_addr        = oldest_r;
    if (ctl.clear) begin
      write_slot_nxt = '0;
      oldest_nxt     = '0;
      held_nxt       = '0;
      ovf_nxt        = '0;
    end else if (cmd.execute) begin
      got_nxt = 1'b0;
      unique case (req_r.req_type)
        ftrb_pkg::REQ_RECORD: begin
          if (ctl.recording_on && code_ok) begin
            wr_en          = 1'b1;
            write_slot_nxt = next_slot(write_slot_r, ctl.size_in_use);
            if (held_r < ctl.size_in_use) begin
              held_nxt = held_r + HW'(1);
            end else begin
              oldest_nxt = next_slot(oldest_r, ctl.size_in_use);
              ovf_nxt    = ovf_r + 32'd1;
            end
          end
        end
        ftrb_pkg::REQ_POP: begin
          if (held_r != '0) begin
            got_nxt    = 1'b1;
            rd_en      = 1'b1;
            oldest_nxt = next_slot(oldest_r, ctl.size_in_use);
            held_nxt   = held_r - HW'(1);
          end
        end
        ftrb_pkg::REQ_PEEK: begin
          if ({1'b0, req_r.peek_offset} < held_r) begin
            got_nxt = 1'b1;
            rd_en   = 1'b1;
            rd_addr = (psum >= CMP_W'(ctl.size_in_use)) ? pdiff[PTR_W-1:0]
                                                         : psum[PTR_W-1:0];
          end
        end
        ftrb_pkg::REQ_CLEAR: begin
          write_slot_nxt = '0;
          oldest_nxt     = '0;
          held_nxt       = '0;
          ovf_nxt        = '0;
        end
        default: got_nxt = 1'b0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      write_slot_r <= '0;
      oldest_r     <= '0;
      held_r       <= '0;
      ovf_r        <= '0;
      got_r        <= 1'b0;
    end else begin
      write_slot_r <= write_slot_nxt;
      oldest_r     <= oldest_nxt;
      held_r       <= held_nxt;
      ovf_r        <= ovf_nxt;
      got_r        <= got_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) mem[write_slot_r] <= wdata;
    if (rd_en) rdata_r <= mem[rd_addr];
  end

  always_comb begin
    out_item.entry_valid     = got_r;
    out_item.out_time        = got_r ? rdata_r.stamp    : '0;
    out_item.out_event       = got_r ? rdata_r.code     : '0;
    out_item.out_task        = got_r ? rdata_r.task_num : '0;
    out_item.out_small_param = got_r ? rdata_r.small_p  : '0;
    out_item.out_large_param = got_r ? rdata_r.large_p  : '0;
    out_item.entries_held    = held_r;
    out_item.overflow_total  = ovf_r;
  end

endmodule

[hw/rtl/filtered_trace_ring_buffer.sv]
// filtered_trace_ring_buffer: top level of the filtered trace capture ring
// depends on ftrb_pkg, ftrb_cfg, ftrb_ctrl and ftrb_dp
//
//   channel  ports                                  handshake
//   input    start, busy, in_item                   beat when start & !busy
//   result   out_strobe, out_item                   one-cycle strobe, no stall
//   config   cfg_valid, cfg_ready, cfg_index, cfg_data  beat when valid & ready
//
// every request goes through capture, execute (one memory port access and the
// pointer update) and respond; busy is high in execute and respond, so requests never overlap
// the result appears on the cycle after execute for exactly one cycle
// reset is synchronous on rst_n: ring empty, recording off, size 256, filter all ones
// no clearing pass runs after reset; the ring is read only where it was written
// cfg_ready is always high; a ring size write empties the ring
module filtered_trace_ring_buffer #(
  parameter int RING_DEPTH  = 256,
  parameter int EVENT_CODES = 256
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  output logic                            busy,
  input  ftrb_pkg::in_item_t              in_item,
  output logic                            out_strobe,
  output ftrb_pkg::out_item_t             out_item,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [ftrb_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [ftrb_pkg::CFG_DATA_W-1:0] cfg_data
);

  ftrb_pkg::cfg_ctl_t     ctl;
  ftrb_pkg::dp_cmd_t      cmd;
  logic [EVENT_CODES-1:0] filter;

  ftrb_cfg #(
    .RING_DEPTH  (RING_DEPTH),
    .EVENT_CODES (EVENT_CODES)
  ) u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .ctl       (ctl),
    .filter    (filter)
  );

  ftrb_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .out_strobe (out_strobe),
    .cmd        (cmd)
  );

  ftrb_dp #(
    .RING_DEPTH  (RING_DEPTH),
    .EVENT_CODES (EVENT_CODES)
  ) u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (cmd),
    .in_item  (in_item),
    .ctl      (ctl),
    .filter   (filter),
    .out_item (out_item)
  );

endmodule

[tb/sv/filtered_trace_ring_buffer_test.sv]
// filtered_trace_ring_buffer_test: self-checking bench for the filtered trace capture ring
// drives record, pop, peek and clear requests plus register writes, predicts every result
// depends on ftrb_pkg and filtered_trace_ring_buffer
module filtered_trace_ring_buffer_test;
  timeunit 1ns;
  timeprecision 1ps;

  import ftrb_pkg::*;

  localparam int RING_DEPTH = 256;
  localparam int IDLE_LIMIT = 2000;
  localparam logic [CFG_IDX_W-1:0] CFG_FILTER_3  = CFG_FILTER_0 + 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_LO = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_HI = 3'd7;

  typedef enum logic [1:0] {
    OP_REQ,
    OP_CFG,
    OP_DRAIN
  } op_kind_t;

  typedef struct packed {
    op_kind_t                kind;
    in_item_t                item;
    logic [CFG_IDX_W-1:0]    idx;
    logic [CFG_DATA_W-1:0]   data;
    logic [7:0]              gap;
  } trace_op_t;

  logic                  clk;
  logic                  rst_n;
  logic                  start;
  logic                  busy;
  in_item_t              in_item;
  logic                  out_strobe;
  out_item_t             out_item;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  filtered_trace_ring_buffer dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_item    (in_item),
    .out_strobe (out_strobe),
    .out_item   (out_item),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  // mirror of the ring
  entry_t      ring_mem [0:RING_DEPTH-1];
  int unsigned wr_slot;
  int unsigned old_slot;
  int unsigned held;
  logic [31:0] overwrites;
  logic        rec_on;
  logic [8:0]  ring_len;
  logic [63:0] filt [0:3];

  trace_op_t   trace_ops[$];
  out_item_t   predicted_replies[$];
  bit          calm;

  trace_op_t   cur_op;
  bit          have_op;
  bit          draining;
  int unsigned gap_left;
  int unsigned settle_left;
  logic        start_nxt;
  logic        cfgv_nxt;
  logic        stim_done;

  int          mismatches;
  int          idle_cycles;
  out_item_t   want;
  string       bad_fields;

  always #5 clk = ~clk;

  function automatic int unsigned ring_span();
    if (ring_len == 9'd0) return 1;
    if (ring_len > RING_DEPTH) return RING_DEPTH;
    return ring_len;
  endfunction

  function automatic void empty_ring();
    wr_slot = 0;
    old_slot = 0;
    held = 0;
    overwrites = '0;
  endfunction

  function automatic void apply_setting(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    case (idx)
      CFG_RECORDING: begin
        rec_on = val[0];
      end
      CFG_RING_SIZE: begin
        ring_len = val[8:0];
        empty_ring();
      end
      default: begin
        if (idx >= CFG_FILTER_0 && idx <= CFG_FILTER_3) filt[idx - CFG_FILTER_0] = val;
      end
    endcase
  endfunction

  function automatic out_item_t ring_predict(in_item_t it);
    out_item_t   r;
    entry_t      e;
    bit          hit;
    int unsigned span;
    r = '0;
    e = '0;
    hit = 0;
    span = ring_span();
    case (it.req_type)
      REQ_RECORD: begin
        if (rec_on && filt[it.event_code[7:6]][it.event_code[5:0]]) begin
          e.stamp = it.time_stamp;
          e.code = it.event_code;
          e.task_num = it.task_number;
          e.small_p = it.small_param;
          e.large_p = it.large_param;
          ring_mem[wr_slot] = e;
          wr_slot = (wr_slot + 1 >= span) ? 0 : wr_slot + 1;
          if (held < span) begin
            held = held + 1;
          end else begin
            old_slot = (old_slot + 1 >= span) ? 0 : old_slot + 1;
            overwrites = overwrites + 32'd1;
          end
        end
      end
      REQ_POP: begin
        if (held != 0) begin
          e = ring_mem[old_slot];
          hit = 1;
          old_slot = (old_slot + 1 >= span) ? 0 : old_slot + 1;
          held = held - 1;
        end
      end
      REQ_PEEK: begin
        if (it.peek_offset < held) begin
          e = ring_mem[(old_slot + it.peek_offset) % span];
          hit = 1;
        end
      end
      default: begin
        empty_ring();
      end
    endcase
    if (hit) begin
      r.entry_valid = 1'b1;
      r.out_time = e.stamp;
      r.out_event = e.code;
      r.out_task = e.task_num;
      r.out_small_param = e.small_p;
      r.out_large_param = e.large_p;
    end
    r.entries_held = held[8:0];
    r.overflow_total = overwrites;
    return r;
  endfunction

  function automatic logic [7:0] pick_gap();
    int unsigned roll;
    if (calm) return 8'd0;
    roll = $urandom_range(0, 99);
    if (roll < 60) return 8'd0;
    if (roll < 92) return 8'($urandom_range(1, 3));
    return 8'($urandom_range(10, 40));
  endfunction

  function automatic void push_req(in_item_t it);
    trace_op_t op;
    op = '0;
    op.kind = OP_REQ;
    op.item = it;
    op.gap = pick_gap();
    trace_ops.push_back(op);
  endfunction

  function automatic void push_cfg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    trace_op_t op;
    op = '0;
    op.kind = OP_CFG;
    op.idx = idx;
    op.data = val;
    op.gap = pick_gap();
    trace_ops.push_back(op);
  endfunction

  function automatic void push_drain();
    trace_op_t op;
    op = '0;
    op.kind = OP_DRAIN;
    op.gap = pick_gap();
    trace_ops.push_back(op);
  endfunction

  function automatic in_item_t req(logic [1:0] kind, logic [7:0] code, logic [7:0] off);
    in_item_t it;
    it.req_type = kind;
    it.event_code = code;
    it.task_number = 8'($urandom);
    it.small_param = 16'($urandom);
    it.large_param = $urandom;
    it.time_stamp = $urandom;
    it.peek_offset = off;
    return it;
  endfunction

  function automatic in_item_t rand_req(bit big, int unsigned reach);
    int unsigned roll;
    logic [1:0]  kind;
    logic [7:0]  off;
    roll = $urandom_range(0, 99);
    if (big) begin
      kind = (roll < 90) ? REQ_RECORD : (roll < 95) ? REQ_POP : REQ_PEEK;
    end else begin
      kind = (roll < 55) ? REQ_RECORD : (roll < 75) ? REQ_POP : (roll < 95) ? REQ_PEEK : REQ_CLEAR;
    end
    off = ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'($urandom_range(0, reach));
    return req(kind, 8'($urandom), off);
  endfunction

  function automatic logic [63:0] filter_word(int mode, int k);
    case (mode)
      0: return '1;
      1: return {$urandom, $urandom};
      2: return (k % 2 == 1) ? '1 : '0;
      default: return {$urandom, $urandom} | {$urandom, $urandom};
    endcase
  endfunction

  // driver
  always @(posedge clk) begin
    if (rst_n) begin
      start_nxt = start;
      cfgv_nxt = cfg_valid;
      if (start && !busy) begin
        predicted_replies.push_back(ring_predict(in_item));
        start_nxt = 1'b0;
      end
      if (cfg_valid && cfg_ready) begin
        apply_setting(cfg_index, cfg_data);
        cfgv_nxt = 1'b0;
      end
      if (!start_nxt && !cfgv_nxt) begin
        if (draining) begin
          if (predicted_replies.size() == 0) begin
            if (settle_left == 0) draining = 1'b0;
            else settle_left = settle_left - 1;
          end
        end else begin
          if (!have_op && trace_ops.size() != 0) begin
            cur_op = trace_ops.pop_front();
            have_op = 1'b1;
            gap_left = cur_op.gap;
          end
          if (have_op) begin
            if (gap_left != 0) begin
              gap_left = gap_left - 1;
            end else begin
              have_op = 1'b0;
              case (cur_op.kind)
                OP_REQ: begin
                  in_item <= cur_op.item;
                  start_nxt = 1'b1;
                end
                OP_CFG: begin
                  cfg_index <= cur_op.idx;
                  cfg_data <= cur_op.data;
                  cfgv_nxt = 1'b1;
                end
                default: begin
                  draining = 1'b1;
                  settle_left = 3;
                end
              endcase
            end
          end
        end
      end
      start <= start_nxt;
      cfg_valid <= cfgv_nxt;
      stim_done <= !start_nxt && !cfgv_nxt && !have_op && !draining && trace_ops.size() == 0;
    end
  end

  // monitor
  always @(posedge clk) begin
    if (rst_n && out_strobe) begin
      if (predicted_replies.size() == 0) begin
        mismatches = mismatches + 1;
        if (mismatches <= 10) $display("unexpected result beat: got %h", out_item);
      end else begin
        want = predicted_replies.pop_front();
        bad_fields = "";
        if (out_item.entry_valid !== want.entry_valid) bad_fields = {bad_fields, " entry_valid"};
        if (out_item.out_time !== want.out_time) bad_fields = {bad_fields, " out_time"};
        if (out_item.out_event !== want.out_event) bad_fields = {bad_fields, " out_event"};
        if (out_item.out_task !== want.out_task) bad_fields = {bad_fields, " out_task"};
        if (out_item.out_small_param !== want.out_small_param)
          bad_fields = {bad_fields, " out_small_param"};
        if (out_item.out_large_param !== want.out_large_param)
          bad_fields = {bad_fields, " out_large_param"};
        if (out_item.entries_held !== want.entries_held) bad_fields = {bad_fields, " entries_held"};
        if (out_item.overflow_total !== want.overflow_total)
          bad_fields = {bad_fields, " overflow_total"};
        if (bad_fields != "") begin
          mismatches = mismatches + 1;
          if (mismatches <= 10)
            $display("result mismatch in%s: expected %h got %h", bad_fields, want, out_item);
        end
      end
    end
  end

  // watchdog on cycles without any beat
  always @(posedge clk) begin
    if (rst_n) begin
      if ((start && !busy) || (cfg_valid && cfg_ready) || out_strobe) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("[filtered_trace_ring_buffer] ERROR");
        $finish;
      end
    end
  end

  initial begin
    in_item_t    it;
    logic [8:0]  sizes [0:9];
    int          ph;
    int          n;
    int          count;
    int          mode;
    int          k;
    int unsigned reach;
    bit          big;

    clk = 1'b0;
    rst_n = 1'b0;
    start = 1'b0;
    in_item = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    have_op = 1'b0;
    draining = 1'b0;
    gap_left = 0;
    settle_left = 0;
    stim_done = 1'b0;
    mismatches = 0;
    idle_cycles = 0;
    rec_on = 1'b0;
    ring_len = RING_SIZE_RESET;
    for (k = 0; k < 4; k++) filt[k] = '1;
    empty_ring();
    calm = 0;

    // recording off after reset, empty ring
    push_req(req(REQ_RECORD, 8'd0, 8'd0));
    push_req(req(REQ_POP, 8'd5, 8'd0));
    push_req(req(REQ_PEEK, 8'd5, 8'd0));
    push_req(req(REQ_CLEAR, 8'd5, 8'd0));
    push_drain();
    push_cfg(CFG_RECORDING, 64'd1);
    push_cfg(CFG_RING_SIZE, 64'd2);
    push_cfg(CFG_UNUSED_HI, '1);
    push_cfg(CFG_FILTER_0, ~64'd1);
    push_cfg(CFG_FILTER_3, {1'b0, {63{1'b1}}});
    // filtered codes, extremes, wrap with overwrite
    push_req(req(REQ_RECORD, 8'd0, 8'd0));
    push_req(req(REQ_RECORD, 8'd255, 8'd0));
    it = '1;
    it.req_type = REQ_RECORD;
    it.event_code = 8'd1;
    push_req(it);
    it = '0;
    it.req_type = REQ_RECORD;
    it.event_code = 8'd254;
    push_req(it);
    push_req(req(REQ_PEEK, 8'd9, 8'd1));
    push_req(req(REQ_PEEK, 8'd9, 8'd2));
    push_req(req(REQ_RECORD, 8'd128, 8'd0));
    push_req(req(REQ_PEEK, 8'd9, 8'd255));
    push_req(req(REQ_POP, 8'd9, 8'd0));
    push_req(req(REQ_POP, 8'd9, 8'd0));
    push_req(req(REQ_POP, 8'd9, 8'd0));
    push_req(req(REQ_RECORD, 8'd63, 8'd0));
    push_req(req(REQ_CLEAR, 8'd9, 8'd0));
    // size zero acts as one
    push_drain();
    push_cfg(CFG_RING_SIZE, 64'd0);
    push_cfg(CFG_FILTER_0, '1);
    push_cfg(CFG_FILTER_3, '1);
    push_req(req(REQ_RECORD, 8'd77, 8'd0));
    push_req(req(REQ_RECORD, 8'd78, 8'd0));
    push_req(req(REQ_PEEK, 8'd9, 8'd0));
    push_req(req(REQ_POP, 8'd9, 8'd0));
    push_req(req(REQ_POP, 8'd9, 8'd0));
    // oversize clamps to the built depth
    push_drain();
    push_cfg(CFG_RING_SIZE, 64'd511);
    push_cfg(CFG_RECORDING, 64'd0);
    push_req(req(REQ_RECORD, 8'd10, 8'd0));
    push_req(req(REQ_PEEK, 8'd9, 8'd0));

    sizes = '{9'd3, 9'd1, 9'd256, 9'd2, 9'd0, 9'd7, 9'd16, 9'd511, 9'd5, 9'd4};
    for (ph = 0; ph < 10; ph++) begin
      calm = (ph % 3 == 2);
      big = (ph == 2);
      mode = big ? 0 : ph % 4;
      reach = (sizes[ph] == 0) ? 1 : (sizes[ph] > 255) ? 255 : sizes[ph];
      push_drain();
      push_cfg(CFG_RECORDING, ({$urandom, $urandom} & ~64'd1) | ((ph == 4) ? 64'd0 : 64'd1));
      push_cfg(CFG_RING_SIZE, ({$urandom, $urandom} & ~64'h1ff) | 64'(sizes[ph]));
      for (k = 0; k < 4; k++) push_cfg(CFG_FILTER_0 + 3'(k), filter_word(mode, k));
      if (ph % 5 == 1) push_cfg(CFG_UNUSED_LO, {$urandom, $urandom});
      count = big ? 400 : 70;
      for (n = 0; n < count; n++) begin
        if (n == count / 2) begin
          push_drain();
          if (ph == 4) push_cfg(CFG_RECORDING, 64'd1);
        end
        push_req(rand_req(big, reach));
      end
    end

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    while (!stim_done || predicted_replies.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (mismatches == 0 && predicted_replies.size() == 0) begin
      $display("[filtered_trace_ring_buffer] OK");
    end else begin
      $display("[filtered_trace_ring_buffer] ERROR");
    end
    $finish;
  end

endmodule
